// File: design/rgb_to_yuv420_converter_top_defines.svh
// Assertion macros shared by the converter's RTL.
`ifndef RGB_TO_YUV420_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define R2Y_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2y assertion failed");

// Check that cons holds in the cycle after ante.
`define R2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2y assertion failed");

`endif

// File: design/r2y_pkg.sv
// Types and constants for the RGB to YCbCr 4:2:0 converter.
package r2y_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 24;
    localparam int COEF_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // BT.601 studio-swing coefficients, unsigned Q16, truncated
    localparam logic [COEF_W-1:0] C_Y_R  = 16'd16842;
    localparam logic [COEF_W-1:0] C_Y_G  = 16'd33030;
    localparam logic [COEF_W-1:0] C_Y_B  = 16'd6422;
    localparam logic [COEF_W-1:0] C_CB_R = 16'd9699;
    localparam logic [COEF_W-1:0] C_CB_G = 16'd19070;
    localparam logic [COEF_W-1:0] C_CB_B = 16'd28770;
    localparam logic [COEF_W-1:0] C_CR_R = 16'd28770;
    localparam logic [COEF_W-1:0] C_CR_G = 16'd24117;
    localparam logic [COEF_W-1:0] C_CR_B = 16'd4653;

    localparam logic [7:0]       LUMA_OFFSET  = 8'd16;
    localparam logic [SUM_W-1:0] CHROMA_BIAS  = 24'd8388608;  // 128 in Q16
    localparam logic [7:0]       LUMA_MIN     = 8'd16;
    localparam logic [7:0]       LUMA_MAX     = 8'd235;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       chroma_valid;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic chroma_valid;
        logic frame_end;
    } raster_flags_t;

endpackage

// File: design/rgb_to_yuv420_converter_top.sv
// Top level of the RGB to YCbCr 4:2:0 pixel converter.
// The converter takes one RGB pixel per beat in raster order and returns one
// result beat per pixel: BT.601 studio-swing luma for every pixel, plus Cb and
// Cr (sampled from the top-left pixel of each 2x2 block, no averaging) with
// chroma_valid on even rows and even columns; cb and cr read zero elsewhere.
// frame_end marks the last pixel of the frame. Frame width and height live in
// registers 0 and 1 (reset 640 x 480); zero acts as one and sizes above
// MAX_DIM act as MAX_DIM. Write them only while the converter is idle; a
// column past a smaller new width wraps on the next pixel, a row at the row end.
// Throughput is one pixel per clock while the result side does not stall. An
// accepted pixel beat reaches the result beat through one input register and
// one result register, with the color matrix between them. While the result
// register is stalled the input register still takes one more pixel.
`include "rgb_to_yuv420_converter_top_defines.svh"

module rgb_to_yuv420_converter_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  r2y_pkg::pixel_t                 pix_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output r2y_pkg::result_t                res_data
);
    import r2y_pkg::*;

    logic          pix_accept;
    logic          res_adv;
    logic          s1_adv;
    raster_flags_t flags;
    result_t       matrix_out;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    pixel_t        s1_pix_reg;
    raster_flags_t s1_flags_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    result_t       res_data_reg;

    // Position counters advance on every accepted pixel beat.
    r2y_raster #(
        .MAX_DIM (MAX_DIM)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (pix_accept),
        .flags     (flags)
    );

    r2y_matrix u_matrix (
        .pix   (s1_pix_reg),
        .flags (s1_flags_reg),
        .res   (matrix_out)
    );

    // The result register can load when it is empty or being taken.
    // Hold the input register only when it is full and cannot move on.
    always_comb
    begin
        res_adv        = !res_valid_reg || !res_stall;
        s1_adv         = s1_valid_reg && res_adv;
        pix_stall      = s1_valid_reg && !res_adv;
        pix_accept     = pix_valid && !pix_stall;
        s1_valid_next  = pix_accept || (s1_valid_reg && !s1_adv);
        res_valid_next = res_adv ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: capture the pixel with its raster flags, then the converted result.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pix_reg   <= pix_data;
            s1_flags_reg <= flags;
        end
        if (s1_adv)
        begin
            res_data_reg <= matrix_out;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Chroma fields read zero on pixels that carry no chroma.
    `R2Y_ASSERT_SAME(a_chroma_zero, clk, rst_n,
        res_valid && !res_data.chroma_valid, res_data.cb == '0 && res_data.cr == '0)
    // Studio-swing luma stays within its legal range.
    `R2Y_ASSERT_SAME(a_luma_range, clk, rst_n,
        res_valid, res_data.luma >= LUMA_MIN && res_data.luma <= LUMA_MAX)
    // A full input register facing a stalled result must stall the input side.
    `R2Y_ASSERT_SAME(a_no_overrun, clk, rst_n,
        s1_valid_reg && res_valid_reg && res_stall, pix_stall)
    // A stalled result beat is not replaced.
    `R2Y_ASSERT_NEXT(a_res_hold, clk, rst_n,
        res_valid_reg && res_stall, res_valid_reg && $stable(res_data_reg))

endmodule

// File: design/r2y_raster.sv
// Frame size registers and raster position counters.
module r2y_raster #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            step,
    output r2y_pkg::raster_flags_t          flags
);
    import r2y_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic             row_end;
    logic             last_row;

    // Zero acts as one, oversize clamps to MAX_DIM.
    function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_W-1:0] size);
        logic [CMP_W-1:0] v;
        v = CMP_W'(size);
        if (v == '0)
        begin
            v = CMP_W'(1);
        end
        if (v > CMP_W'(MAX_DIM))
        begin
            v = CMP_W'(MAX_DIM);
        end
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_eff  = eff_size(frame_width_reg);
        height_eff = eff_size(frame_height_reg);
        col_inc    = CMP_W'(col_reg) + CMP_W'(1);
        row_inc    = CMP_W'(row_reg) + CMP_W'(1);
        row_end    = col_inc >= width_eff;
        last_row   = row_inc >= height_eff;

        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : CNT_W'(row_inc);
            end
            else
            begin
                col_next = CNT_W'(col_inc);
            end
        end

        flags.chroma_valid = !col_reg[0] && !row_reg[0];
        flags.frame_end    = row_end && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: design/r2y_matrix.sv
// Color matrix: RGB to studio-swing Y, Cb, Cr.
module r2y_matrix (
    input  r2y_pkg::pixel_t         pix,
    input  r2y_pkg::raster_flags_t  flags,
    output r2y_pkg::result_t        res
);
    import r2y_pkg::*;

    logic [SUM_W-1:0] r_ext;
    logic [SUM_W-1:0] g_ext;
    logic [SUM_W-1:0] b_ext;
    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;

    always_comb
    begin
        r_ext = SUM_W'(pix.red);
        g_ext = SUM_W'(pix.green);
        b_ext = SUM_W'(pix.blue);

        y_sum = r_ext * SUM_W'(C_Y_R) + g_ext * SUM_W'(C_Y_G) + b_ext * SUM_W'(C_Y_B);
        // Both sums stay non-negative, so the top byte is an exact floor.
        cb_sum = CHROMA_BIAS + b_ext * SUM_W'(C_CB_B)
                 - r_ext * SUM_W'(C_CB_R) - g_ext * SUM_W'(C_CB_G);
        cr_sum = CHROMA_BIAS + r_ext * SUM_W'(C_CR_R)
                 - g_ext * SUM_W'(C_CR_G) - b_ext * SUM_W'(C_CR_B);

        res.luma         = y_sum[SUM_W-1:SUM_W-8] + LUMA_OFFSET;
        res.cb           = flags.chroma_valid ? cb_sum[SUM_W-1:SUM_W-8] : '0;
        res.cr           = flags.chroma_valid ? cr_sum[SUM_W-1:SUM_W-8] : '0;
        res.chroma_valid = flags.chroma_valid;
        res.frame_end    = flags.frame_end;
    end

endmodule

// File: tb/rgb_to_yuv420_converter_top_tb.sv
// Self-checking testbench for the RGB to YCbCr 4:2:0 pixel converter.
//
// Pixels go in through a queue-fed driver that works in random bursts; results
// are taken by a monitor behind a receiver that stalls on its own pattern. Each
// accepted pixel beat is run through a local BT.601 predictor with its own copy
// of the frame size registers and raster counters, and the predicted result is
// queued. Each result beat is checked field by field against the oldest entry.
// Frame size registers are rewritten only after every predicted result has
// arrived, across directed cases (reset size, tiny frames, zero and oversize
// sizes, odd sizes, a size cut below the running column) and random phases.
module rgb_to_yuv420_converter_top_tb;
    import r2y_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int RANDOM_PIXELS = 1200;
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int TAIL_CYCLES   = 10;      // slack after the last result
    localparam int CYCLE_LIMIT   = 200000;

    // BT.601 studio-swing coefficients, floor(c * 65536)
    localparam int unsigned K_Y_R  = 16842;
    localparam int unsigned K_Y_G  = 33030;
    localparam int unsigned K_Y_B  = 6422;
    localparam int unsigned K_CB_R = 9699;
    localparam int unsigned K_CB_G = 19070;
    localparam int unsigned K_CB_B = 28770;
    localparam int unsigned K_CR_R = 28770;
    localparam int unsigned K_CR_G = 24117;
    localparam int unsigned K_CR_B = 4653;
    localparam int unsigned Q16_HALF_SCALE = 8388608;   // 128.0 in Q16
    localparam int unsigned Y_OFFSET       = 16;

    typedef enum
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pixel_t               pix_data  = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    result_t              res_data;

    // Predictor state: register copies and raster position
    logic [CFG_W-1:0] frame_width_copy  = 13'd640;
    logic [CFG_W-1:0] frame_height_copy = 13'd480;
    int unsigned      raster_col = 0;
    int unsigned      raster_row = 0;

    pixel_t      pixel_q[$];          // pixels waiting for the driver
    result_t     yuv_expected_q[$];   // predicted results, oldest first

    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned results_seen    = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;

    // Sender burst shaping and pause control
    int unsigned burst_left    = 0;
    int unsigned gap_left      = 0;
    bit          sender_paused = 1'b0;

    // Receiver stall shaping and long hold-off request
    stall_mode_e stall_mode    = STALL_NONE;
    int unsigned stall_span    = 0;
    int unsigned res_hold_left = 0;
    bit          long_hold_req = 1'b0;

    rgb_to_yuv420_converter_top #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_data (pix_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Zero acts as one, anything above MAX_DIM clamps to MAX_DIM.
    function automatic int unsigned active_size(logic [CFG_W-1:0] size_value);
        if (size_value == 0)
            return 1;
        if (size_value > MAX_DIM)
            return MAX_DIM;
        return 32'(size_value);
    endfunction

    // Convert one pixel and advance the raster position.
    function automatic result_t predict_yuv(pixel_t px);
        int unsigned r, g, b, w, h, y_sum, cb_sum, cr_sum;
        bit          row_end, last_row, chroma;
        result_t     res;
        r        = 32'(px.red);
        g        = 32'(px.green);
        b        = 32'(px.blue);
        w        = active_size(frame_width_copy);
        h        = active_size(frame_height_copy);
        row_end  = (raster_col + 1) >= w;
        last_row = (raster_row + 1) >= h;
        chroma   = (raster_col % 2 == 0) && (raster_row % 2 == 0);
        y_sum    = ((K_Y_R * r + K_Y_G * g + K_Y_B * b) >> 16) + Y_OFFSET;
        cb_sum   = 0;
        cr_sum   = 0;
        if (chroma)
        begin
            // Sums stay non-negative: add the bias and positive term first.
            cb_sum = ((Q16_HALF_SCALE + K_CB_B * b) - K_CB_R * r - K_CB_G * g) >> 16;
            cr_sum = ((Q16_HALF_SCALE + K_CR_R * r) - K_CR_G * g - K_CR_B * b) >> 16;
        end
        res.luma         = y_sum[7:0];
        res.cb           = cb_sum[7:0];
        res.cr           = cr_sum[7:0];
        res.chroma_valid = chroma;
        res.frame_end    = row_end && last_row;
        if (row_end)
        begin
            raster_col = 0;
            raster_row = last_row ? 0 : raster_row + 1;
        end
        else
        begin
            raster_col = raster_col + 1;
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // Mostly uniform pixels, with the odd channel pinned to an extreme.
    function automatic pixel_t random_pixel();
        logic [23:0] raw;
        pixel_t      px;
        raw = 24'($urandom);
        px  = raw;
        if ($urandom_range(0, 7) == 0)
            px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    task automatic queue_pixel(pixel_t px);
        pixel_q.push_back(px);
        pixels_queued++;
    endtask

    // Block must be idle here: every queued pixel has produced its result.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_FRAME_WIDTH)
            frame_width_copy = value;
        else
            frame_height_copy = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every pixel queued so far has come back as a result beat.
    task automatic wait_for_idle();
        @(posedge clk);
        while (results_seen != pixels_queued)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string field, int unsigned expv, int unsigned actv);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, actv);
        fail_count++;
    endtask

    // Driver: predict on every accepted beat, then refill the slot from the
    // queue, honoring burst gaps and a pause request. A stalled beat is held.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                yuv_expected_q.push_back(predict_yuv(pix_data));
                pixels_accepted++;
            end
            if (!pix_valid || !pix_stall)
            begin
                if (gap_left != 0)
                begin
                    pix_valid <= 1'b0;
                    gap_left--;
                end
                else if (pixel_q.size() != 0 && !sender_paused)
                begin
                    pix_valid <= 1'b1;
                    pix_data  <= pixel_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        // Some bursts run back to back with no gap at all.
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch stall pattern every so often; a long hold-off request
    // overrides the pattern and is counted down here.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 200);
        end
        else
        begin
            stall_span--;
        end
        if (long_hold_req && res_hold_left == 0)
        begin
            res_hold_left = HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (res_hold_left != 0)
        begin
            res_stall <= 1'b1;
            res_hold_left--;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:  res_stall <= 1'b0;
                STALL_LIGHT: res_stall <= ($urandom_range(0, 2) == 0);
                STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
                default:     res_stall <= stall_span[2];
            endcase
        end
    end

    // Monitor: check every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (yuv_expected_q.size() == 0)
            begin
                $display("%0t: result beat with no pixel pending: expected none, actual %h",
                         $time, res_data);
                fail_count++;
            end
            else
            begin
                exp_res = yuv_expected_q.pop_front();
                if (res_data.luma !== exp_res.luma)
                    report_mismatch("luma", 32'(exp_res.luma), 32'(res_data.luma));
                if (res_data.cb !== exp_res.cb)
                    report_mismatch("cb", 32'(exp_res.cb), 32'(res_data.cb));
                if (res_data.cr !== exp_res.cr)
                    report_mismatch("cr", 32'(exp_res.cr), 32'(res_data.cr));
                if (res_data.chroma_valid !== exp_res.chroma_valid)
                    report_mismatch("chroma_valid", 32'(exp_res.chroma_valid),
                                    32'(res_data.chroma_valid));
                if (res_data.frame_end !== exp_res.frame_end)
                    report_mismatch("frame_end", 32'(exp_res.frame_end),
                                    32'(res_data.frame_end));
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int unsigned     phase;
        int unsigned     n;
        int unsigned     random_count;
        int unsigned     pick;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size 640 x 480: mid-grey and color extremes, with black, white,
        // red, green and blue on the even columns where chroma is produced.
        queue_pixel(make_pixel(8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(8'h80, 8'h80, 8'h80));
        queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(8'h00, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(8'hFF, 8'h00, 8'h00));
        queue_pixel(make_pixel(8'hFF, 8'h00, 8'hFF));
        queue_pixel(make_pixel(8'h00, 8'hFF, 8'h00));
        queue_pixel(make_pixel(8'hFF, 8'hFF, 8'h00));
        queue_pixel(make_pixel(8'h00, 8'h00, 8'hFF));
        wait_for_idle();

        // Cut the frame to 2 x 2 mid-row: the column is already past the new
        // width, so the row wraps on the next pixel.
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        repeat (6) queue_pixel(random_pixel());
        wait_for_idle();

        // Zero sizes act as one: every pixel ends a frame, and each after the first carries chroma.
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(8'hFF, 8'h00, 8'hFF));
        wait_for_idle();

        // Odd sizes.
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd5);
        repeat (5) queue_pixel(random_pixel());
        wait_for_idle();

        // Oversize clamps to MAX_DIM.
        write_reg(CFG_FRAME_WIDTH, 13'd8191);
        write_reg(CFG_FRAME_HEIGHT, 13'd4096);
        repeat (2) queue_pixel(random_pixel());
        wait_for_idle();

        // Random phases: mostly small even frames so frames wrap often,
        // some odd, zero, huge and clamped sizes.
        phase        = 0;
        random_count = 0;
        while (random_count < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    w_val = CFG_W'(2 * $urandom_range(1, 6));
                    h_val = CFG_W'(2 * $urandom_range(1, 4));
                end
                6:
                begin
                    w_val = CFG_W'($urandom_range(0, 9));
                    h_val = CFG_W'($urandom_range(0, 7));
                end
                7:
                begin
                    w_val = CFG_W'($urandom_range(0, 8191));
                    h_val = CFG_W'($urandom_range(1, 3));
                end
                8:
                begin
                    w_val = CFG_W'($urandom_range(1, 4));
                    h_val = CFG_W'($urandom_range(0, 8191));
                end
                default:
                begin
                    w_val = $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
                    h_val = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
                end
            endcase

            // Sometimes rewrite only one register; the counters carry over.
            pick = $urandom_range(0, 3);
            if (pick != 1)
                write_reg(CFG_FRAME_WIDTH, w_val);
            if (pick != 0)
                write_reg(CFG_FRAME_HEIGHT, h_val);

            n = (phase == 2 || phase == 9) ? 150 : $urandom_range(20, 100);
            repeat (n) queue_pixel(random_pixel());

            // Hold off the receiver long enough for the block to fill and
            // stall its input while the driver keeps offering beats.
            if (phase == 2 || phase == 9)
                long_hold_req = 1'b1;

            // Pause the sender halfway and let every result drain.
            if (phase == 5 || phase == 11)
            begin
                while (pixel_q.size() > n / 2)
                    @(posedge clk);
                sender_paused = 1'b1;
                @(posedge clk);
                while (pix_valid || results_seen != pixels_accepted)
                    @(posedge clk);
                sender_paused = 1'b0;
            end

            wait_for_idle();
            random_count += n;
            phase++;
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (yuv_expected_q.size() != 0)
        begin
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, yuv_expected_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
